// File: rtl/core/cia_pkg.sv
// Shared constants, types and helper functions for the complex integer ALU.
// No dependencies; every file in the block imports this package.
package cia_pkg;

    // Operand width taken from the low bits of each input field.
    localparam int DATA_WIDTH = 16;
    // Fixed port widths.
    localparam int FIELD_W    = 16;
    localparam int RES_W      = 33;

    // Derived datapath widths.
    localparam int PROD_W     = 2 * DATA_WIDTH;      // signed product
    localparam int SUM_W      = PROD_W + 1;          // signed sum of two products
    localparam int MAG_W      = PROD_W;              // dividend / divisor magnitude
    localparam int DIV_STAGES = MAG_W;               // one quotient bit per stage
    localparam int EXT_W      = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int WRAP_W     = (SUM_W > RES_W) ? SUM_W : RES_W;
    localparam int QWRAP_W    = (MAG_W > RES_W) ? MAG_W : RES_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cia_op_t;

    typedef logic signed [DATA_WIDTH-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic [MAG_W-1:0]             mag_t;
    typedef logic [RES_W-1:0]             res_t;

    // Per-transaction sideband carried alongside the divider lanes.
    typedef struct packed {
        logic is_div;   // result comes from the divider
        logic dz;       // divide by zero
        logic neg_r;    // sign of real quotient
        logic neg_i;    // sign of imaginary quotient
        res_t alt_r;    // add/sub/mul real result
        res_t alt_i;    // add/sub/mul imaginary result
    } cia_side_t;

    // Field to operand: low DATA_WIDTH bits, two's complement.
    function automatic opnd_t to_operand(input logic [FIELD_W-1:0] f);
        logic [EXT_W-1:0] e;
        e = EXT_W'(f);
        return opnd_t'(e[DATA_WIDTH-1:0]);
    endfunction

    // Wrap an exact signed value to the result width.
    function automatic res_t fit_sum(input sum_t x);
        logic signed [WRAP_W-1:0] t;
        t = WRAP_W'(x);
        return t[RES_W-1:0];
    endfunction

    // Apply the sign to a quotient magnitude and wrap to the result width.
    function automatic res_t fit_quo(input logic neg, input mag_t q);
        logic [QWRAP_W-1:0] t;
        t = QWRAP_W'(q);
        if (neg)
        begin
            t = -t;
        end
        return t[RES_W-1:0];
    endfunction

endpackage

// File: rtl/core/cia_divider.sv
// Pipelined restoring divider: two unsigned lanes sharing one divisor,
// one quotient bit per stage, sideband carried along. Depends on cia_pkg.
module cia_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  cia_pkg::cia_side_t        in_side,
    input  logic [cia_pkg::MAG_W-1:0] in_num_r,
    input  logic [cia_pkg::MAG_W-1:0] in_num_i,
    input  logic [cia_pkg::MAG_W-1:0] in_den,
    output logic                      out_valid,
    output cia_pkg::cia_side_t        out_side,
    output logic [cia_pkg::MAG_W-1:0] out_quo_r,
    output logic [cia_pkg::MAG_W-1:0] out_quo_i
);
    import cia_pkg::*;

    localparam int NSTG = DIV_STAGES;

    // rem: partial remainder; quo: dividend bits shifting out, quotient bits in
    typedef struct packed {
        mag_t rem;
        mag_t quo;
    } lane_t;

    typedef struct packed {
        cia_side_t side;
        mag_t      den;
        lane_t     lr;
        lane_t     li;
    } stage_t;

    logic [NSTG:0] vld_reg;
    stage_t        stg_reg  [0:NSTG];
    stage_t        stg_next [0:NSTG];

    function automatic lane_t div_step(input lane_t l, input mag_t d);
        logic [MAG_W:0] trial;
        lane_t          r;
        trial = {l.rem, l.quo[MAG_W-1]};
        r.quo = {l.quo[MAG_W-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            trial    = trial - {1'b0, d};
            r.quo[0] = 1'b1;
        end
        r.rem = trial[MAG_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        stg_next[0].side   = in_side;
        stg_next[0].den    = in_den;
        stg_next[0].lr.rem = '0;
        stg_next[0].lr.quo = in_num_r;
        stg_next[0].li.rem = '0;
        stg_next[0].li.quo = in_num_i;
        for (int k = 0; k < NSTG; k++)
        begin
            stg_next[k+1].side = stg_reg[k].side;
            stg_next[k+1].den  = stg_reg[k].den;
            stg_next[k+1].lr   = div_step(stg_reg[k].lr, stg_reg[k].den);
            stg_next[k+1].li   = div_step(stg_reg[k].li, stg_reg[k].den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NSTG];
    assign out_side  = stg_reg[NSTG].side;
    assign out_quo_r = stg_reg[NSTG].lr.quo;
    assign out_quo_i = stg_reg[NSTG].li.quo;

    // Finished division leaves a remainder below the divisor.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_side.is_div && !out_side.dz |->
            (stg_reg[NSTG].lr.rem < stg_reg[NSTG].den) &&
            (stg_reg[NSTG].li.rem < stg_reg[NSTG].den))
        else $error("divider remainder not below divisor");

    // Divide-by-zero only ever tags divide transactions.
    a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_side.dz |-> out_side.is_div)
        else $error("divide-by-zero flag on non-divide transaction");

endmodule

// File: rtl/core/complex_integer_alu_unit.sv
// Top level of the complex integer ALU: operand pipeline, product and sum
// stages, pipelined divider and output register. Depends on cia_pkg, cia_divider.
//
// Usage
//   Request channel (op_valid/op_ready): one transaction carries op and the two
//   complex operands a_real + a_imag*i and b_real + b_imag*i.
//   Result channel (res_valid/res_ready): one transaction per request, in order,
//   with res_real, res_imag and div_zero.
//   op selects add, subtract, multiply or divide. Divide truncates toward zero;
//   a zero divisor returns zero results with div_zero set.
//   Throughput: one transaction per cycle, every operation alike, while the
//   pipe is not stalled. Path: operand, product and sum registers, then the
//   restoring divider, which retires one quotient bit per stage, and the output
//   register; add, subtract and multiply ride the same pipe.
//   Reset clears every valid bit; nothing is in flight afterwards.
//   Stall: all stages advance together while the output register is empty or
//   being taken. When res_ready is low with a result waiting, the whole pipe
//   holds and op_ready drops; no transaction is lost or repeated.
module complex_integer_alu_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               op_valid,
    output logic                               op_ready,
    input  logic [1:0]                         op,
    input  logic signed [cia_pkg::FIELD_W-1:0] a_real,
    input  logic signed [cia_pkg::FIELD_W-1:0] a_imag,
    input  logic signed [cia_pkg::FIELD_W-1:0] b_real,
    input  logic signed [cia_pkg::FIELD_W-1:0] b_imag,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic signed [cia_pkg::RES_W-1:0]   res_real,
    output logic signed [cia_pkg::RES_W-1:0]   res_imag,
    output logic                               div_zero
);
    import cia_pkg::*;

    logic adv;      // whole pipe advances this cycle

    // stage 1: captured operands
    logic    s1_vld_reg;
    cia_op_t s1_op_reg;
    opnd_t   s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // stage 2: products, squares, add/sub
    logic                       s2_vld_reg;
    cia_op_t                    s2_op_reg;
    prod_t                      s2_p_ac_reg, s2_p_bd_reg, s2_p_ad_reg, s2_p_cb_reg;
    prod_t                      s2_sq_r_reg, s2_sq_i_reg;
    logic signed [DATA_WIDTH:0] s2_as_r_reg, s2_as_i_reg;
    prod_t                      s2_p_ac_next, s2_p_bd_next, s2_p_ad_next, s2_p_cb_next;
    prod_t                      s2_sq_r_next, s2_sq_i_next;
    logic signed [DATA_WIDTH:0] s2_as_r_next, s2_as_i_next;

    // stage 3: sums, divisor, non-divide result
    logic    s3_vld_reg;
    cia_op_t s3_op_reg;
    sum_t    s3_num_r_reg, s3_num_i_reg, s3_num_r_next, s3_num_i_next;
    mag_t    s3_den_reg, s3_den_next;
    res_t    s3_alt_r_reg, s3_alt_i_reg, s3_alt_r_next, s3_alt_i_next;
    sum_t    mul_r, mul_i;

    // divider hand-off
    cia_side_t dv_side;
    sum_t      num_r_abs, num_i_abs;
    mag_t      dv_num_r, dv_num_i;
    logic      dv_out_valid;
    cia_side_t dv_out_side;
    mag_t      dv_quo_r, dv_quo_i;

    // output register
    logic res_valid_reg;
    res_t res_real_reg, res_imag_reg, res_real_next, res_imag_next;
    logic div_zero_reg, div_zero_next;

    assign adv      = !res_valid_reg || res_ready;
    assign op_ready = adv;

    // ---------------- stage 2 ----------------
    always_comb
    begin
        s2_p_ac_next = PROD_W'(s1_ar_reg) * PROD_W'(s1_br_reg);
        s2_p_bd_next = PROD_W'(s1_ai_reg) * PROD_W'(s1_bi_reg);
        s2_p_ad_next = PROD_W'(s1_ar_reg) * PROD_W'(s1_bi_reg);
        s2_p_cb_next = PROD_W'(s1_br_reg) * PROD_W'(s1_ai_reg);
        s2_sq_r_next = PROD_W'(s1_br_reg) * PROD_W'(s1_br_reg);
        s2_sq_i_next = PROD_W'(s1_bi_reg) * PROD_W'(s1_bi_reg);
        if (s1_op_reg == OP_SUB)
        begin
            s2_as_r_next = (DATA_WIDTH+1)'(s1_ar_reg) - (DATA_WIDTH+1)'(s1_br_reg);
            s2_as_i_next = (DATA_WIDTH+1)'(s1_ai_reg) - (DATA_WIDTH+1)'(s1_bi_reg);
        end
        else
        begin
            s2_as_r_next = (DATA_WIDTH+1)'(s1_ar_reg) + (DATA_WIDTH+1)'(s1_br_reg);
            s2_as_i_next = (DATA_WIDTH+1)'(s1_ai_reg) + (DATA_WIDTH+1)'(s1_bi_reg);
        end
    end

    // ---------------- stage 3 ----------------
    always_comb
    begin
        mul_r         = SUM_W'(s2_p_ac_reg) - SUM_W'(s2_p_bd_reg);
        mul_i         = SUM_W'(s2_p_ad_reg) + SUM_W'(s2_p_cb_reg);
        s3_num_r_next = SUM_W'(s2_p_ac_reg) + SUM_W'(s2_p_bd_reg);
        s3_num_i_next = SUM_W'(s2_p_cb_reg) - SUM_W'(s2_p_ad_reg);
        s3_den_next   = $unsigned(s2_sq_r_reg) + $unsigned(s2_sq_i_reg);
        unique case (s2_op_reg)
            OP_ADD, OP_SUB:
            begin
                s3_alt_r_next = fit_sum(SUM_W'(s2_as_r_reg));
                s3_alt_i_next = fit_sum(SUM_W'(s2_as_i_reg));
            end
            OP_MUL:
            begin
                s3_alt_r_next = fit_sum(mul_r);
                s3_alt_i_next = fit_sum(mul_i);
            end
            default:
            begin
                s3_alt_r_next = '0;
                s3_alt_i_next = '0;
            end
        endcase
    end

    // ---------------- divider input: sign / magnitude ----------------
    always_comb
    begin
        dv_side.is_div = (s3_op_reg == OP_DIV);
        dv_side.dz     = (s3_op_reg == OP_DIV) && (s3_den_reg == '0);
        dv_side.neg_r  = s3_num_r_reg[SUM_W-1];
        dv_side.neg_i  = s3_num_i_reg[SUM_W-1];
        dv_side.alt_r  = s3_alt_r_reg;
        dv_side.alt_i  = s3_alt_i_reg;
        num_r_abs      = s3_num_r_reg[SUM_W-1] ? -s3_num_r_reg : s3_num_r_reg;
        num_i_abs      = s3_num_i_reg[SUM_W-1] ? -s3_num_i_reg : s3_num_i_reg;
        dv_num_r       = num_r_abs[MAG_W-1:0];
        dv_num_i       = num_i_abs[MAG_W-1:0];
    end

    cia_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_vld_reg),
        .in_side   (dv_side),
        .in_num_r  (dv_num_r),
        .in_num_i  (dv_num_i),
        .in_den    (s3_den_reg),
        .out_valid (dv_out_valid),
        .out_side  (dv_out_side),
        .out_quo_r (dv_quo_r),
        .out_quo_i (dv_quo_i)
    );

    // ---------------- output select ----------------
    always_comb
    begin
        div_zero_next = dv_out_side.dz;
        if (!dv_out_side.is_div)
        begin
            res_real_next = dv_out_side.alt_r;
            res_imag_next = dv_out_side.alt_i;
        end
        else if (dv_out_side.dz)
        begin
            res_real_next = '0;
            res_imag_next = '0;
        end
        else
        begin
            res_real_next = fit_quo(dv_out_side.neg_r, dv_quo_r);
            res_imag_next = fit_quo(dv_out_side.neg_i, dv_quo_i);
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= op_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            res_valid_reg <= dv_out_valid;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= cia_op_t'(op);
            s1_ar_reg    <= to_operand(a_real);
            s1_ai_reg    <= to_operand(a_imag);
            s1_br_reg    <= to_operand(b_real);
            s1_bi_reg    <= to_operand(b_imag);

            s2_op_reg    <= s1_op_reg;
            s2_p_ac_reg  <= s2_p_ac_next;
            s2_p_bd_reg  <= s2_p_bd_next;
            s2_p_ad_reg  <= s2_p_ad_next;
            s2_p_cb_reg  <= s2_p_cb_next;
            s2_sq_r_reg  <= s2_sq_r_next;
            s2_sq_i_reg  <= s2_sq_i_next;
            s2_as_r_reg  <= s2_as_r_next;
            s2_as_i_reg  <= s2_as_i_next;

            s3_op_reg    <= s2_op_reg;
            s3_num_r_reg <= s3_num_r_next;
            s3_num_i_reg <= s3_num_i_next;
            s3_den_reg   <= s3_den_next;
            s3_alt_r_reg <= s3_alt_r_next;
            s3_alt_i_reg <= s3_alt_i_next;

            res_real_reg <= res_real_next;
            res_imag_reg <= res_imag_next;
            div_zero_reg <= div_zero_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_real  = res_real_reg;
    assign res_imag  = res_imag_reg;
    assign div_zero  = div_zero_reg;

    // A flagged divide always returns zero parts.
    a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && div_zero |-> (res_real == '0) && (res_imag == '0))
        else $error("divide-by-zero transaction with nonzero result");

    // The pipe only holds off new requests behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !op_ready |-> res_valid)
        else $error("request stalled without a pending result");

    // Divisor squares are never negative in the product stage.
    a_sq_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> !s2_sq_r_reg[PROD_W-1] && !s2_sq_i_reg[PROD_W-1])
        else $error("negative divisor square");

endmodule
